### src/miller_rabin_witness_test_assert.svh
// Assertion macros for the checker in mrw_checker.sv.
`ifndef MILLER_RABIN_WITNESS_TEST_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define MRW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MRW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mrw_pkg.sv
`timescale 1ns / 1ps
package mrw_pkg;
    localparam int NUM_WIDTH = 63;
    // One bit of the multiplier per cell.
    localparam int NUM_CELLS = NUM_WIDTH;

    typedef logic [NUM_WIDTH-1:0] t_num;
    typedef logic [1:0]           t_verdict;

    localparam t_verdict VERDICT_PRIME     = 2'd0;
    localparam t_verdict VERDICT_COMPOSITE = 2'd1;
    localparam t_verdict VERDICT_BADWIT    = 2'd2;

    // (a + b) mod m for a, b < m.
    function automatic t_num add_mod(input t_num a, input t_num b, input t_num m);
        logic [NUM_WIDTH:0] s;
        logic [NUM_WIDTH:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        add_mod = (s >= {1'b0, m}) ? d[NUM_WIDTH-1:0] : s[NUM_WIDTH-1:0];
    endfunction

    // Data handed from one cell to the next.
    typedef struct packed {
        logic active;
        t_num acc;
        t_num addend;
        logic mbit;
    } t_link;
endpackage

### src/mrw_if.sv
`timescale 1ns / 1ps
interface mrw_in_if
    import mrw_pkg::*;
    ();
    logic valid;
    logic ready;
    t_num candidate;
    t_num witness;
    modport source (output valid, candidate, witness, input ready);
    modport sink   (input valid, candidate, witness, output ready);
endinterface

interface mrw_out_if
    import mrw_pkg::*;
    ();
    logic     valid;
    logic     ready;
    t_verdict verdict;
    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

### src/mrw_cell.sv
`timescale 1ns / 1ps
// One multiplier bit step: conditional add, then doubling of the addend.
module mrw_cell
    import mrw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_num  i_mod,
    input  t_link i_link,
    output t_link o_link
);
    t_link r_link;
    t_num  n_acc;
    t_num  n_add;

    always_comb begin
        n_acc = i_link.mbit ? add_mod(i_link.acc, i_link.addend, i_mod) : i_link.acc;
        n_add = add_mod(i_link.addend, i_link.addend, i_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.active <= 1'b0;
        end else begin
            r_link.active <= i_link.active;
        end
        r_link.acc    <= n_acc;
        r_link.addend <= n_add;
        r_link.mbit   <= i_link.mbit;
    end

    assign o_link = r_link;
endmodule

### src/mrw_mulmod.sv
`timescale 1ns / 1ps
// (a * b) mod m over a chain of cells, one multiplier bit per cell.
module mrw_mulmod
    import mrw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_num i_a,
    input  t_num i_b,
    input  t_num i_mod,
    output logic o_done,
    output t_num o_prod
);
    t_link w_link [NUM_CELLS+1];
    t_num  r_mult;
    t_link n_first;

    // Multiplier bits are held in r_mult: each later cell reads its own bit from it.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mult <= i_b;
        end
    end

    always_comb begin
        n_first.active = i_start;
        n_first.acc    = '0;
        n_first.addend = i_a;
        n_first.mbit   = i_b[0];
    end
    assign w_link[0] = n_first;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        t_link w_in;
        always_comb begin
            w_in = w_link[g];
            if (g > 0) begin
                w_in.mbit = r_mult[g];
            end
        end
        mrw_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_mod  (i_mod),
            .i_link (w_in),
            .o_link (w_link[g+1])
        );
    end

    assign o_done = w_link[NUM_CELLS].active;
    assign o_prod = w_link[NUM_CELLS].acc;
endmodule

### src/miller_rabin_witness_test.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload               Handshake
// in       in   candidate, witness    valid/ready
// out      out  verdict               valid/ready
// Trivial cases finish without the multiplier. Otherwise each modular product
// passes through the cell chain, which sets the overall run time.
// Reset is synchronous, active low, and clears the control state.
// One item at a time; a held verdict waits for ready while the next item
// may already be transferred in.
module miller_rabin_witness_test
    import mrw_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    mrw_in_if.sink    i_in,
    mrw_out_if.source o_out
);
    typedef enum logic [2:0] {
        S_IDLE, S_STRIP, S_POW, S_POW_WAIT, S_SQ, S_SQ_WAIT, S_DONE
    } t_state;

    t_state   r_state;
    t_num     r_n, r_nm1, r_exp, r_expo, r_acc, r_sq, r_v;
    logic     r_sel;      // in S_POW_WAIT: 0 acc product, 1 square
    logic     r_start;
    t_num     r_a, r_b;
    logic     r_ovalid;
    t_verdict r_verdict;
    t_verdict r_res;

    logic w_done;
    t_num w_prod;
    logic w_take;

    mrw_mulmod u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_a    (r_a),
        .i_b    (r_b),
        .i_mod  (r_n),
        .o_done (w_done),
        .o_prod (w_prod)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign w_take        = i_in.valid && i_in.ready;
    assign o_out.valid   = r_ovalid;
    assign o_out.verdict = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            // S_DONE reloads the output register on its own.
            if (r_ovalid && o_out.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_n   <= i_in.candidate;
                        r_nm1 <= i_in.candidate - t_num'(1);
                        r_exp <= i_in.candidate - t_num'(1);
                        r_sq  <= i_in.witness;
                        r_acc <= t_num'(1);
                        if (i_in.candidate < t_num'(2) ||
                            (i_in.candidate != t_num'(2) && !i_in.candidate[0])) begin
                            r_res   <= VERDICT_COMPOSITE;
                            r_state <= S_DONE;
                        end else if (i_in.witness == '0 ||
                                     i_in.witness >= i_in.candidate) begin
                            r_res   <= VERDICT_BADWIT;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_STRIP;
                        end
                    end
                end
                S_STRIP: begin
                    // Drop one factor of two per cycle.
                    if (r_exp[0]) begin
                        r_expo  <= r_exp;
                        r_state <= S_POW;
                    end else begin
                        r_exp <= r_exp >> 1;
                    end
                end
                S_POW: begin
                    if (r_exp == '0) begin
                        r_v     <= r_acc;
                        r_state <= S_SQ;
                    end else if (r_exp[0]) begin
                        r_a <= r_acc; r_b <= r_sq; r_sel <= 1'b0;
                        r_start <= 1'b1;
                        r_state <= S_POW_WAIT;
                    end else begin
                        r_a <= r_sq; r_b <= r_sq; r_sel <= 1'b1;
                        r_start <= 1'b1;
                        r_state <= S_POW_WAIT;
                    end
                end
                S_POW_WAIT: begin
                    if (w_done) begin
                        if (!r_sel) begin
                            r_acc <= w_prod;
                            r_exp[0] <= 1'b0;
                        end else begin
                            r_sq  <= w_prod;
                            r_exp <= r_exp >> 1;
                        end
                        r_state <= S_POW;
                    end
                end
                S_SQ: begin
                    if (r_expo == r_nm1 || r_v == t_num'(1) || r_v == r_nm1) begin
                        r_res <= (r_v != r_nm1 && !r_expo[0]) ? VERDICT_COMPOSITE
                                                               : VERDICT_PRIME;
                        r_state <= S_DONE;
                    end else begin
                        r_a <= r_v; r_b <= r_v;
                        r_start <= 1'b1;
                        r_state <= S_SQ_WAIT;
                    end
                end
                S_SQ_WAIT: begin
                    if (w_done) begin
                        r_v     <= w_prod;
                        r_expo  <= r_expo << 1;
                        r_state <= S_SQ;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid  <= 1'b1;
                        r_verdict <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### src/mrw_checker.sv
`timescale 1ns / 1ps
`include "miller_rabin_witness_test_assert.svh"
module mrw_checker
    import mrw_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_ready,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_verdict i_verdict
);
    `MRW_ASSERT_IMP(a_verdict_code, i_clk, i_rst_n, i_out_valid,
        (i_verdict == VERDICT_PRIME || i_verdict == VERDICT_COMPOSITE ||
         i_verdict == VERDICT_BADWIT), "verdict code out of range")
    `MRW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_verdict), "stalled verdict changed")
    `MRW_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready, "second item taken while one is at work")
endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_verdict  (o_out.verdict)
);
